// ===== rtl/core/ips_pkg.sv =====
package ips_pkg;

  localparam int DATA_W   = 32;
  localparam int DIV_BITS = 48;
  localparam int DIV_CW   = $clog2(DIV_BITS);

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN    = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_DRIVE_FLOOR   = 3'd3,
    REG_DRIVE_CEILING = 3'd4,
    REG_ACCUM_LIMIT   = 3'd5,
    REG_SAMPLE_PERIOD = 3'd6
  } ips_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_DIFF,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_DIV,
    S_DSAT,
    S_SUM1,
    S_SUM2,
    S_CLAMP,
    S_DRV,
    S_OUT
  } ips_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ips_div_stat_t;

  // saturate a 34-bit signed value to signed 32 bits
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ips_mul_unit.sv =====
module ips_mul_unit (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] q
);

  logic signed [63:0] prod_r;
  logic signed [63:0] rnd;
  logic signed [47:0] shr;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  // round half up, floor by 2^16, then saturate
  always_comb begin
    rnd = prod_r + 64'sh8000;
    shr = rnd[63:16];
    if (shr[47:31] == {17{1'b0}} || shr[47:31] == {17{1'b1}}) begin
      q = shr[31:0];
    end else if (shr[47]) begin
      q = 32'sh8000_0000;
    end else begin
      q = 32'sh7FFF_FFFF;
    end
  end

endmodule

// ===== rtl/core/ips_div_unit.sv =====
module ips_div_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [47:0]          dividend,
  input  logic [30:0]          divisor,
  output ips_pkg::ips_div_stat_t stat,
  output logic [47:0]          quotient
);

  logic [47:0]              wq_r, wq_nxt;
  logic [30:0]              rem_r, rem_nxt;
  logic [30:0]              dvs_r, dvs_nxt;
  logic [ips_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [31:0]              trial;
  logic                     fits;

  always_comb begin
    trial   = {rem_r, wq_r[47]};
    fits    = trial >= {1'b0, dvs_r};
    wq_nxt  = wq_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      wq_nxt   = dividend;
      rem_nxt  = '0;
      // a zero period divides as one ulp
      dvs_nxt  = (divisor == '0) ? 31'd1 : divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      wq_nxt  = {wq_r[46:0], fits};
      rem_nxt = fits ? 31'(trial - {1'b0, dvs_r}) : trial[30:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ips_pkg::DIV_CW'(ips_pkg::DIV_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    wq_r  <= wq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = wq_r;

endmodule

// ===== rtl/core/incremental_pid_step_unit.sv =====
// sequence: an item steps through ERR, DIFF, M1-M5, DIV (48-step divider), DSAT, SUM1,
//   SUM2, CLAMP, DRV and OUT; DIV and DSAT are skipped when the derivative term is skipped
//   (first step after reset or after a clear); one item at a time, taken only in idle;
//   in_tready rises with out_tvalid, so the next item is taken while the result waits
// reset: synchronous active-low rst_n clears the sequencer, history, output valid and
//   configuration (sample_period to 1.0, everything else to zero)
module incremental_pid_step_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] target, [63:32] measured, [95:64] feedforward
  input  logic        in_tuser,   // [0] clear_history
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] drive
  output logic [1:0]  out_tuser   // [0] accum_limited, [1] drive_limited
);

  // configuration registers
  logic signed [31:0] kp_r, ki_r, kd_r, floor_r, ceil_r;
  logic [30:0]        lim_r, period_r;

  // controller history
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] last_err_r, last_err_nxt;
  logic signed [31:0] last_meas_r, last_meas_nxt;
  logic               first_r, first_nxt;

  // working registers for one item
  ips_pkg::ips_state_t state_r, state_nxt;
  logic signed [31:0] tgt_r, tgt_nxt, meas_r, meas_nxt, ff_r, ff_nxt;
  logic signed [31:0] err_r, err_nxt, derr_r, derr_nxt, dm_r, dm_nxt;
  logic signed [31:0] dp_r, dp_nxt, qi_r, qi_nxt, qd_r, qd_nxt, di_r, di_nxt;
  logic signed [31:0] dd_r, dd_nxt;
  logic               qd_neg_r, qd_neg_nxt;
  logic signed [33:0] part_r, part_nxt;
  logic signed [31:0] acc_sat_r, acc_sat_nxt;
  logic               acc_flag_r, acc_flag_nxt;
  logic signed [31:0] drv_r, drv_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        out_data_r, out_data_nxt;
  logic [1:0]         out_user_r, out_user_nxt;

  // shared multiplier and divider
  logic signed [31:0] mul_a, mul_b, mul_q;
  logic               div_start;
  logic [47:0]        div_dividend, div_quot;
  ips_pkg::ips_div_stat_t div_stat;

  logic signed [31:0] lim_s, neg_lim, qd_abs, clamp_v;
  logic signed [31:0] drv_c;
  logic               drv_flag;
  logic               in_fire;

  ips_mul_unit u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  ips_div_unit u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (period_r),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  assign in_tready = (state_r == ips_pkg::S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign lim_s     = $signed({1'b0, lim_r});
  assign neg_lim   = -lim_s;

  // magnitude of the rounded kd product, placed above 16 fraction bits
  assign qd_abs       = qd_r[31] ? -qd_r : qd_r;
  assign div_dividend = {qd_abs, 16'h0000};

  // multiplier operands by step
  always_comb begin
    unique case (state_r)
      ips_pkg::S_M1: begin
        mul_a = kp_r;
        mul_b = derr_r;
      end
      ips_pkg::S_M2: begin
        mul_a = ki_r;
        mul_b = err_r;
      end
      ips_pkg::S_M3: begin
        mul_a = kd_r;
        mul_b = dm_r;
      end
      ips_pkg::S_M4: begin
        mul_a = qi_r;
        mul_b = $signed({1'b0, period_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // accumulator clamp: upper bound first, then lower
  always_comb begin
    clamp_v = acc_sat_r;
    if (clamp_v > lim_s) begin
      clamp_v = lim_s;
    end
    if (clamp_v < neg_lim) begin
      clamp_v = neg_lim;
    end
  end

  // drive clamp: ceiling first, so the floor wins when they cross
  always_comb begin
    drv_c    = drv_r;
    drv_flag = 1'b0;
    if (drv_c > ceil_r) begin
      drv_c    = ceil_r;
      drv_flag = 1'b1;
    end
    if (drv_c < floor_r) begin
      drv_c    = floor_r;
      drv_flag = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    last_err_nxt  = last_err_r;
    last_meas_nxt = last_meas_r;
    first_nxt     = first_r;
    tgt_nxt       = tgt_r;
    meas_nxt      = meas_r;
    ff_nxt        = ff_r;
    err_nxt       = err_r;
    derr_nxt      = derr_r;
    dm_nxt        = dm_r;
    dp_nxt        = dp_r;
    qi_nxt        = qi_r;
    qd_nxt        = qd_r;
    di_nxt        = di_r;
    dd_nxt        = dd_r;
    qd_neg_nxt    = qd_neg_r;
    part_nxt      = part_r;
    acc_sat_nxt   = acc_sat_r;
    acc_flag_nxt  = acc_flag_r;
    drv_nxt       = drv_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    div_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ips_pkg::S_IDLE: begin
        if (in_fire) begin
          tgt_nxt  = in_tdata[31:0];
          meas_nxt = in_tdata[63:32];
          ff_nxt   = in_tdata[95:64];
          // clear empties the history before the step
          if (in_tuser) begin
            acc_nxt       = '0;
            last_err_nxt  = '0;
            last_meas_nxt = '0;
            first_nxt     = 1'b1;
          end
          state_nxt = ips_pkg::S_ERR;
        end
      end
      ips_pkg::S_ERR: begin
        err_nxt   = ips_pkg::sat34(34'(tgt_r) - 34'(meas_r));
        state_nxt = ips_pkg::S_DIFF;
      end
      ips_pkg::S_DIFF: begin
        derr_nxt  = ips_pkg::sat34(34'(err_r) - 34'(last_err_r));
        dm_nxt    = ips_pkg::sat34(34'(meas_r) - 34'(last_meas_r));
        state_nxt = ips_pkg::S_M1;
      end
      ips_pkg::S_M1: begin
        state_nxt = ips_pkg::S_M2;
      end
      ips_pkg::S_M2: begin
        dp_nxt    = mul_q;
        state_nxt = ips_pkg::S_M3;
      end
      ips_pkg::S_M3: begin
        qi_nxt    = mul_q;
        state_nxt = ips_pkg::S_M4;
      end
      ips_pkg::S_M4: begin
        qd_nxt    = mul_q;
        state_nxt = ips_pkg::S_M5;
      end
      ips_pkg::S_M5: begin
        di_nxt     = mul_q;
        qd_neg_nxt = qd_r[31];
        if (first_r) begin
          // no derivative term on the first step
          dd_nxt    = '0;
          state_nxt = ips_pkg::S_SUM1;
        end else begin
          div_start = 1'b1;
          state_nxt = ips_pkg::S_DIV;
        end
      end
      ips_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_nxt = ips_pkg::S_DSAT;
        end
      end
      ips_pkg::S_DSAT: begin
        // d term is minus the truncated quotient, so its sign is opposite to kd*dm
        if (qd_neg_r) begin
          dd_nxt = (div_quot[47:31] != '0) ? 32'sh7FFF_FFFF : $signed(div_quot[31:0]);
        end else begin
          dd_nxt = (div_quot[47:31] != '0) ? 32'sh8000_0000 : -$signed(div_quot[31:0]);
        end
        state_nxt = ips_pkg::S_SUM1;
      end
      ips_pkg::S_SUM1: begin
        part_nxt  = 34'(acc_r) + 34'(dp_r) + 34'(di_r);
        state_nxt = ips_pkg::S_SUM2;
      end
      ips_pkg::S_SUM2: begin
        acc_sat_nxt = ips_pkg::sat34(part_r + 34'(dd_r));
        state_nxt   = ips_pkg::S_CLAMP;
      end
      ips_pkg::S_CLAMP: begin
        acc_nxt       = clamp_v;
        acc_flag_nxt  = (clamp_v != acc_sat_r);
        last_err_nxt  = err_r;
        last_meas_nxt = meas_r;
        first_nxt     = 1'b0;
        state_nxt     = ips_pkg::S_DRV;
      end
      ips_pkg::S_DRV: begin
        drv_nxt   = ips_pkg::sat34(34'(ff_r) + 34'(acc_r));
        state_nxt = ips_pkg::S_OUT;
      end
      ips_pkg::S_OUT: begin
        // wait here while an earlier result still occupies the output register
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = drv_c;
          out_user_nxt  = {drv_flag, acc_flag_r};
          state_nxt     = ips_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ips_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ips_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      last_err_r  <= '0;
      last_meas_r <= '0;
      first_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
      last_err_r  <= last_err_nxt;
      last_meas_r <= last_meas_nxt;
      first_r     <= first_nxt;
    end
    tgt_r      <= tgt_nxt;
    meas_r     <= meas_nxt;
    ff_r       <= ff_nxt;
    err_r      <= err_nxt;
    derr_r     <= derr_nxt;
    dm_r       <= dm_nxt;
    dp_r       <= dp_nxt;
    qi_r       <= qi_nxt;
    qd_r       <= qd_nxt;
    di_r       <= di_nxt;
    dd_r       <= dd_nxt;
    qd_neg_r   <= qd_neg_nxt;
    part_r     <= part_nxt;
    acc_sat_r  <= acc_sat_nxt;
    acc_flag_r <= acc_flag_nxt;
    drv_r      <= drv_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= '0;
      ki_r     <= '0;
      kd_r     <= '0;
      floor_r  <= '0;
      ceil_r   <= '0;
      lim_r    <= '0;
      period_r <= 31'h0001_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ips_pkg::REG_PROP_GAIN:     kp_r     <= cfg_wdata;
        ips_pkg::REG_INTEG_GAIN:    ki_r     <= cfg_wdata;
        ips_pkg::REG_DERIV_GAIN:    kd_r     <= cfg_wdata;
        ips_pkg::REG_DRIVE_FLOOR:   floor_r  <= cfg_wdata;
        ips_pkg::REG_DRIVE_CEILING: ceil_r   <= cfg_wdata;
        ips_pkg::REG_ACCUM_LIMIT:   lim_r    <= cfg_wdata[30:0];
        ips_pkg::REG_SAMPLE_PERIOD: period_r <= cfg_wdata[30:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  // the divider only finishes while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ips_pkg::S_DIV))
    else $error("divider finished outside its wait step");

  // no new item while the divider still works
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  // the clamped accumulator stays within the limit
  a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ips_pkg::S_DRV) |-> (acc_r <= lim_s && acc_r >= neg_lim))
    else $error("accumulator outside its limit");

  // a limited drive sits on the floor or the ceiling
  a_drive_on_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r[1]) |->
      ($signed(out_data_r) == floor_r || $signed(out_data_r) == ceil_r))
    else $error("limited drive not on a bound");
`endif

endmodule
